/* hw/rtl/fra_pkg.sv */
// Shared widths and request and result types for the fraction adder.
`default_nettype none

package fra_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_WIDTH = 2 * OPERAND_WIDTH;
	localparam int SUM_WIDTH = 2 * OPERAND_WIDTH + 1;
	localparam int SHIFT_WIDTH = $clog2(PROD_WIDTH + 1);

	typedef struct packed {
		logic [OPERAND_WIDTH-1:0] num_a;
		logic [OPERAND_WIDTH-1:0] den_a;
		logic [OPERAND_WIDTH-1:0] num_b;
		logic [OPERAND_WIDTH-1:0] den_b;
	} req_t;

	typedef struct packed {
		logic [SUM_WIDTH-1:0]  sum_num;
		logic [PROD_WIDTH-1:0] sum_den;
	} rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/fra_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module fra_div #(
	parameter int WIDTH = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  done,
	output logic [WIDTH-1:0]      quot
);

	localparam int CW = $clog2(WIDTH + 1);

	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dsr_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/fraction_add_reduce.sv */
// Top level of the fraction adder that returns the sum in lowest terms.
//
//  Channel   Signals              Direction  Handshake
//  request   start, busy, req     in         taken when start is high and busy is low
//  result    done, rsp            out        done high for one cycle, cannot be stalled
//
// A zero sum over a zero denominator goes from the multiplier steps through the setup
// step straight to the result. Otherwise the binary gcd loop runs, the common power of
// two is shifted back up, and each of the two divisions runs in the bit-serial divider:
// it is launched, iterates once per quotient bit, and hands its quotient over. A zero
// sum or a zero denominator alone skips the gcd but still runs both divisions.
// Reset clears the sequencer and the strobes; the block is ready right after reset.
// Busy falls in the cycle in which done is shown, so the next request can be taken there.
`default_nettype none

module fraction_add_reduce (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire fra_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output fra_pkg::rsp_t      rsp
);

	localparam int W  = fra_pkg::OPERAND_WIDTH;
	localparam int PW = fra_pkg::PROD_WIDTH;
	localparam int NW = fra_pkg::SUM_WIDTH;
	localparam int KW = fra_pkg::SHIFT_WIDTH;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_GINIT = 3'd2;
	localparam logic [2:0] S_GCD   = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DIVN  = 3'd5;
	localparam logic [2:0] S_DIVD  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]    state_q;
	logic [1:0]    mcnt_q;
	logic          div_go_q;
	logic          done_q;
	logic [KW-1:0] k_q;

	fra_pkg::req_t  req_q;
	fra_pkg::rsp_t  rsp_q;
	logic [PW-1:0]  prod_q;
	logic [NW-1:0]  num_q;
	logic [PW-1:0]  den_q;
	logic [NW-1:0]  u_q;
	logic [NW-1:0]  v_q;

	logic [W-1:0]   mul_a;
	logic [W-1:0]   mul_b;
	logic           u_ge_v;
	logic [NW-1:0]  big;
	logic [NW-1:0]  tiny;
	logic [NW-1:0]  diff;
	logic [NW-1:0]  either;
	logic [NW-1:0]  div_dividend;
	logic           div_done;
	logic [NW-1:0]  div_quot;

	always_comb begin
		case (mcnt_q)
			2'd0: begin
				mul_a = req_q.num_a;
				mul_b = req_q.den_b;
			end
			2'd1: begin
				mul_a = req_q.num_b;
				mul_b = req_q.den_a;
			end
			default: begin
				mul_a = req_q.den_a;
				mul_b = req_q.den_b;
			end
		endcase
	end

	assign u_ge_v       = u_q >= v_q;
	assign big          = u_ge_v ? u_q : v_q;
	assign tiny         = u_ge_v ? v_q : u_q;
	assign diff         = big - tiny;
	assign either       = num_q | {1'b0, den_q};
	assign div_dividend = (state_q == S_DIVN) ? num_q : {1'b0, den_q};

	fra_div #(
		.WIDTH(NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go_q),
		.dividend(div_dividend),
		.divisor (u_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mcnt_q   <= '0;
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
						mcnt_q  <= '0;
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 2'd3) begin
						state_q <= S_GINIT;
					end
				end
				S_GINIT: begin
					if (num_q == '0 || den_q == '0) begin
						if (either == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q  <= S_DIVN;
							div_go_q <= 1'b1;
						end
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (u_q == v_q) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (k_q == '0) begin
						state_q  <= S_DIVN;
						div_go_q <= 1'b1;
					end
				end
				S_DIVN: begin
					if (div_done) begin
						state_q  <= S_DIVD;
						div_go_q <= 1'b1;
					end
				end
				S_DIVD: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req;
				end
			end
			S_MUL: begin
				prod_q <= PW'(mul_a) * PW'(mul_b);
				if (mcnt_q == 2'd1) begin
					num_q <= {1'b0, prod_q};
				end else if (mcnt_q == 2'd2) begin
					num_q <= num_q + {1'b0, prod_q};
				end else if (mcnt_q == 2'd3) begin
					den_q <= prod_q;
				end
			end
			S_GINIT: begin
				k_q <= '0;
				if (num_q == '0 || den_q == '0) begin
					u_q <= either;
				end else begin
					u_q <= num_q;
					v_q <= {1'b0, den_q};
				end
			end
			S_GCD: begin
				if (u_q != v_q) begin
					case ({u_q[0], v_q[0]})
						2'b00: begin
							u_q <= u_q >> 1;
							v_q <= v_q >> 1;
							k_q <= k_q + 1'b1;
						end
						2'b01: begin
							u_q <= u_q >> 1;
						end
						2'b10: begin
							v_q <= v_q >> 1;
						end
						default: begin
							if (u_ge_v) begin
								u_q <= diff >> 1;
							end else begin
								v_q <= diff >> 1;
							end
						end
					endcase
				end
			end
			S_SHIFT: begin
				if (k_q != '0) begin
					u_q <= u_q << 1;
					k_q <= k_q - 1'b1;
				end
			end
			S_DIVN: begin
				if (div_done) begin
					num_q <= div_quot;
				end
			end
			S_DIVD: begin
				if (div_done) begin
					den_q <= div_quot[PW-1:0];
				end
			end
			default: begin
				rsp_q.sum_num <= num_q;
				rsp_q.sum_den <= den_q;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// A result only follows a request that was being worked on.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// An accepted request makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// The gcd loop never sees a zero operand, so it always terminates.
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD) |-> (u_q != '0 && v_q != '0))
		else $error("zero operand inside gcd loop");

	// The divider finishes only while the sequencer waits for it.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVN || state_q == S_DIVD))
		else $error("divider finished outside a division step");

	// The divisor is never zero when a division is launched.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> (u_q != '0))
		else $error("division by zero launched");

endmodule

`default_nettype wire
